@@ design/mcvr_pkg.sv @@
// ----------------------------------------------------------------------------
// mcvr_pkg
// Shared types and constants of the mesh chunk vertex remapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcvr_pkg;

  localparam int unsigned MAX_TRIANGLES_DEF   = 8192;
  localparam int unsigned REMAP_ENTRIES_DEF   = 32768;
  localparam int unsigned SECTION_ID_BITS_DEF = 8;

  localparam int unsigned LOCAL_LIMIT  = 32768;
  localparam int unsigned EPOCH_W      = 16;
  localparam logic [13:0] MAX_TRI_RST  = 14'd5000;
  localparam logic [31:0] HASH_MULT    = 32'd2654435761;
  localparam int unsigned HASH_SHIFT   = 17;

  typedef enum logic [1:0] {
    KIND_OPEN = 2'd0,
    KIND_COPY = 2'd1,
    KIND_TRI  = 2'd2,
    KIND_DROP = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_OPEN,
    S_WIPE,
    S_DECIDE,
    S_HASH,
    S_SLOT,
    S_PROBE,
    S_INSERT,
    S_DRYEND,
    S_TRI,
    S_DROP
  } state_e;

  typedef struct packed {
    logic  latch;
    logic  open_chunk;
    logic  wipe;
    logic  slot_hash;
    logic  slot_next;
    logic  rec_hit;
    logic  count_new;
    logic  nnew_rst;
    logic  corner_rst;
    logic  corner_next;
    logic  insert;
    logic  tri_inc;
    logic  out_load;
    kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic need_open;
    logic fits3;
    logic fits_nnew;
    logic hit;
    logic empty;
    logic exhausted;
    logic out_free;
    logic wipe_done;
    logic epoch_wrap;
    logic corner_last;
  } status_t;

endpackage

@@ design/mcvr_dp.sv @@
// ----------------------------------------------------------------------------
// mcvr_dp
// Datapath: input latch, hash unit, remap table with epoch tags, chunk
// counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcvr_dp #(
  parameter int unsigned MAX_TRIANGLES   = mcvr_pkg::MAX_TRIANGLES_DEF,
  parameter int unsigned REMAP_ENTRIES   = mcvr_pkg::REMAP_ENTRIES_DEF,
  parameter int unsigned SECTION_ID_BITS = mcvr_pkg::SECTION_ID_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcvr_pkg::cmd_t      cmd_i,
  output mcvr_pkg::status_t   st_o,
  input  logic                cfg_we_i,
  input  logic [13:0]         cfg_wdata_i,
  input  logic [31:0]         corner_a_i,
  input  logic [31:0]         corner_b_i,
  input  logic [31:0]         corner_c_i,
  input  logic [30:0]         section_vertex_count_i,
  input  logic [7:0]          section_id_i,
  input  logic                section_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [15:0]         chunk_number_o,
  output logic [7:0]          chunk_section_o,
  output logic [31:0]         source_vertex_o,
  output logic [14:0]         local_index_o,
  output logic [14:0]         local_a_o,
  output logic [14:0]         local_b_o,
  output logic [14:0]         local_c_o,
  output logic                last_o
);

  localparam int unsigned IDXW = $clog2(REMAP_ENTRIES);
  localparam int unsigned CAP  = (REMAP_ENTRIES < mcvr_pkg::LOCAL_LIMIT) ?
                                 REMAP_ENTRIES : mcvr_pkg::LOCAL_LIMIT;
  localparam int unsigned CVW  = $clog2(CAP + 1);
  localparam int unsigned TRIW = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned EPW  = mcvr_pkg::EPOCH_W;
  localparam logic [7:0]  SEC_MASK = 8'((33'd1 << SECTION_ID_BITS) - 33'd1);
  localparam logic [IDXW:0] LAST_STEP = (IDXW + 1)'(REMAP_ENTRIES - 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(REMAP_ENTRIES - 1);
  localparam logic [EPW-1:0] EPOCH_MAX = {EPW{1'b1}};

  typedef struct packed {
    logic [EPW-1:0] tag;
    logic [31:0]    key;
    logic [14:0]    loc;
  } entry_t;

  entry_t mem [REMAP_ENTRIES];
  entry_t rdata_q;
  entry_t wdata;
  logic   mem_we;
  logic [IDXW-1:0] waddr;

  logic [13:0]      cfg_q;
  logic [31:0]      key_q [3];
  logic [30:0]      count_q;
  logic [7:0]       sec_q;
  logic             start_q;
  logic [1:0]       k_q;
  logic [31:0]      key_sel;
  logic [63:0]      prod_q;
  logic [63:0]      hmix;
  logic [IDXW-1:0]  slot_q, slot_d;
  logic [IDXW:0]    steps_q;
  logic [IDXW-1:0]  clr_q;
  logic [EPW-1:0]   epoch_q;
  logic [CVW-1:0]   cvc_q;
  logic [TRIW-1:0]  tri_q;
  logic [15:0]      next_q, cur_q;
  logic             open_q;
  logic [1:0]       nnew_q;
  logic [14:0]      loc_q [3];
  logic             dup;
  logic [31:0]      limit;

  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [15:0]      chunk_q;
  logic [7:0]       csec_q;
  logic [31:0]      src_q;
  logic [14:0]      lidx_q, la_q, lb_q, lc_q;
  logic             last_q;

  always_comb begin
    case (k_q)
      2'd1:    key_sel = key_q[1];
      2'd2:    key_sel = key_q[2];
      default: key_sel = key_q[0];
    endcase
    case (k_q)
      2'd1:    dup = (key_q[1] == key_q[0]);
      2'd2:    dup = (key_q[2] == key_q[0]) || (key_q[2] == key_q[1]);
      default: dup = 1'b0;
    endcase
  end

  assign hmix = prod_q ^ (prod_q >> mcvr_pkg::HASH_SHIFT);

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.slot_hash) begin
      slot_d = hmix[IDXW-1:0];
    end else if (cmd_i.slot_next) begin
      slot_d = slot_q + 1'b1;
    end
  end

  assign limit = (32'(cfg_q) > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES) : 32'(cfg_q);

  always_comb begin
    st_o.invalid     = ({1'b0, count_q} <= key_q[0]) || ({1'b0, count_q} <= key_q[1]) ||
                       ({1'b0, count_q} <= key_q[2]);
    st_o.need_open   = start_q || !open_q || (32'(tri_q) >= limit);
    st_o.fits3       = (32'(cvc_q) + 32'd3) <= 32'(CAP);
    st_o.fits_nnew   = (32'(cvc_q) + 32'(nnew_q)) <= 32'(CAP);
    st_o.empty       = (rdata_q.tag != epoch_q);
    st_o.hit         = !st_o.empty && (rdata_q.key == key_sel);
    st_o.exhausted   = (steps_q == LAST_STEP) && !st_o.empty && !st_o.hit;
    st_o.out_free    = !out_valid_q || !out_stall_i;
    st_o.wipe_done   = (clr_q == LAST_IDX);
    st_o.epoch_wrap  = (epoch_q == EPOCH_MAX);
    st_o.corner_last = (k_q == 2'd2);
  end

  // remap table
  always_comb begin
    mem_we = cmd_i.wipe || cmd_i.insert;
    waddr  = cmd_i.wipe ? clr_q : slot_q;
    if (cmd_i.wipe) begin
      wdata = '0;
    end else begin
      wdata.tag = epoch_q;
      wdata.key = key_sel;
      wdata.loc = 15'(cvc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[slot_d];
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(key_sel) * 64'(mcvr_pkg::HASH_MULT);
    slot_q <= slot_d;
    if (cmd_i.latch) begin
      key_q[0] <= corner_a_i;
      key_q[1] <= corner_b_i;
      key_q[2] <= corner_c_i;
      count_q  <= section_vertex_count_i;
      sec_q    <= section_id_i & SEC_MASK;
      start_q  <= section_start_i;
    end
    if (cmd_i.slot_hash) begin
      steps_q <= '0;
    end else if (cmd_i.slot_next) begin
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.rec_hit || cmd_i.insert) begin
      case (k_q)
        2'd1:    loc_q[1] <= cmd_i.insert ? 15'(cvc_q) : rdata_q.loc;
        2'd2:    loc_q[2] <= cmd_i.insert ? 15'(cvc_q) : rdata_q.loc;
        default: loc_q[0] <= cmd_i.insert ? 15'(cvc_q) : rdata_q.loc;
      endcase
    end
  end

  // chunk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= mcvr_pkg::MAX_TRI_RST;
      k_q     <= '0;
      nnew_q  <= '0;
      clr_q   <= '0;
      epoch_q <= EPW'(1);
      cvc_q   <= '0;
      tri_q   <= '0;
      next_q  <= '0;
      cur_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.corner_rst) begin
        k_q <= '0;
      end else if (cmd_i.corner_next) begin
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.nnew_rst) begin
        nnew_q <= '0;
      end else if (cmd_i.count_new && !dup) begin
        nnew_q <= nnew_q + 2'd1;
      end
      if (cmd_i.wipe) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.open_chunk) begin
        epoch_q <= (epoch_q == EPOCH_MAX) ? EPW'(1) : epoch_q + 1'b1;
        cvc_q   <= '0;
        tri_q   <= '0;
        open_q  <= 1'b1;
        cur_q   <= next_q;
        next_q  <= next_q + 16'd1;
      end else begin
        if (cmd_i.insert) begin
          cvc_q <= cvc_q + 1'b1;
        end
        if (cmd_i.tri_inc) begin
          tri_q <= tri_q + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q  <= cmd_i.out_kind;
      chunk_q <= (cmd_i.out_kind == mcvr_pkg::KIND_OPEN) ? next_q : cur_q;
      csec_q  <= (cmd_i.out_kind == mcvr_pkg::KIND_OPEN) ? sec_q : 8'd0;
      src_q   <= (cmd_i.out_kind == mcvr_pkg::KIND_COPY) ? key_sel : 32'd0;
      lidx_q  <= (cmd_i.out_kind == mcvr_pkg::KIND_COPY) ? 15'(cvc_q) : 15'd0;
      la_q    <= (cmd_i.out_kind == mcvr_pkg::KIND_TRI) ? loc_q[0] : 15'd0;
      lb_q    <= (cmd_i.out_kind == mcvr_pkg::KIND_TRI) ? loc_q[1] : 15'd0;
      lc_q    <= (cmd_i.out_kind == mcvr_pkg::KIND_TRI) ? loc_q[2] : 15'd0;
      last_q  <= (cmd_i.out_kind == mcvr_pkg::KIND_TRI) ||
                 (cmd_i.out_kind == mcvr_pkg::KIND_DROP);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign chunk_number_o  = chunk_q;
  assign chunk_section_o = csec_q;
  assign source_vertex_o = src_q;
  assign local_index_o   = lidx_q;
  assign local_a_o       = la_q;
  assign local_b_o       = lb_q;
  assign local_c_o       = lc_q;
  assign last_o          = last_q;

endmodule

@@ design/mcvr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcvr_ctrl
// Controller: sequences chunk opening, table walks and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcvr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mcvr_pkg::status_t st_i,
  output mcvr_pkg::cmd_t    cmd_o
);

  mcvr_pkg::state_e state_q, state_d;
  logic dry_q, dry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcvr_pkg::S_INIT;
      dry_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dry_q   <= dry_d;
    end
  end

  assign in_stall_o = (state_q != mcvr_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    dry_d   = dry_q;
    cmd_o   = '0;
    cmd_o.out_kind = mcvr_pkg::KIND_OPEN;
    case (state_q)
      mcvr_pkg::S_INIT: begin
        cmd_o.wipe = 1'b1;
        if (st_i.wipe_done) begin
          state_d = mcvr_pkg::S_IDLE;
        end
      end
      mcvr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = mcvr_pkg::S_CHECK;
        end
      end
      mcvr_pkg::S_CHECK: begin
        state_d = st_i.need_open ? mcvr_pkg::S_OPEN : mcvr_pkg::S_DECIDE;
      end
      mcvr_pkg::S_OPEN: begin
        if (st_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = mcvr_pkg::KIND_OPEN;
          cmd_o.open_chunk = 1'b1;
          state_d = st_i.epoch_wrap ? mcvr_pkg::S_WIPE : mcvr_pkg::S_DECIDE;
        end
      end
      mcvr_pkg::S_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (st_i.wipe_done) begin
          state_d = mcvr_pkg::S_DECIDE;
        end
      end
      mcvr_pkg::S_DECIDE: begin
        cmd_o.corner_rst = 1'b1;
        cmd_o.nnew_rst   = 1'b1;
        dry_d = !st_i.fits3;
        state_d = st_i.invalid ? mcvr_pkg::S_DROP : mcvr_pkg::S_HASH;
      end
      mcvr_pkg::S_HASH: begin
        state_d = mcvr_pkg::S_SLOT;
      end
      mcvr_pkg::S_SLOT: begin
        cmd_o.slot_hash = 1'b1;
        state_d = mcvr_pkg::S_PROBE;
      end
      mcvr_pkg::S_PROBE: begin
        if (st_i.hit || (dry_q && (st_i.empty || st_i.exhausted))) begin
          cmd_o.rec_hit   = !dry_q;
          cmd_o.count_new = dry_q && !st_i.hit;
          if (st_i.corner_last) begin
            state_d = dry_q ? mcvr_pkg::S_DRYEND : mcvr_pkg::S_TRI;
          end else begin
            cmd_o.corner_next = 1'b1;
            state_d = mcvr_pkg::S_HASH;
          end
        end else if (st_i.empty) begin
          state_d = mcvr_pkg::S_INSERT;
        end else begin
          cmd_o.slot_next = 1'b1;
        end
      end
      mcvr_pkg::S_INSERT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = mcvr_pkg::KIND_COPY;
          cmd_o.insert   = 1'b1;
          if (st_i.corner_last) begin
            state_d = mcvr_pkg::S_TRI;
          end else begin
            cmd_o.corner_next = 1'b1;
            state_d = mcvr_pkg::S_HASH;
          end
        end
      end
      mcvr_pkg::S_DRYEND: begin
        cmd_o.corner_rst = 1'b1;
        dry_d = 1'b0;
        state_d = st_i.fits_nnew ? mcvr_pkg::S_HASH : mcvr_pkg::S_DROP;
      end
      mcvr_pkg::S_TRI: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = mcvr_pkg::KIND_TRI;
          cmd_o.tri_inc  = 1'b1;
          state_d = mcvr_pkg::S_IDLE;
        end
      end
      mcvr_pkg::S_DROP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = mcvr_pkg::KIND_DROP;
          state_d = mcvr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mcvr_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free) else $error("result loaded over a held result");
  a_insert_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |-> st_i.empty) else $error("insert into an occupied slot");
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == mcvr_pkg::S_CHECK))
    else $error("accepted item not checked");
  a_open_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.open_chunk |=> (state_q == mcvr_pkg::S_DECIDE || state_q == mcvr_pkg::S_WIPE))
    else $error("chunk open not followed by decide or wipe");
`endif

endmodule

@@ design/mesh_chunk_vertex_remap.sv @@
// ----------------------------------------------------------------------------
// mesh_chunk_vertex_remap
// Splits a triangle stream into chunks and remaps source vertex indices to
// dense per-chunk local indices through a hashed, linearly probed table.
// ----------------------------------------------------------------------------
// One triangle is taken at a time; the next is accepted once the last result
// of the previous one is in the output register. Each corner is hashed and
// then probed through the single registered read port of the table. A chunk
// near a full table first runs a counting walk over the corners before the
// walk that inserts. After reset the table tags are swept before the first
// item is taken, and the sweep repeats inside the item after every 65535
// chunks. REMAP_ENTRIES must be a power of two.
`timescale 1ns / 1ps

module mesh_chunk_vertex_remap #(
  parameter int unsigned MAX_TRIANGLES   = mcvr_pkg::MAX_TRIANGLES_DEF,
  parameter int unsigned REMAP_ENTRIES   = mcvr_pkg::REMAP_ENTRIES_DEF,
  parameter int unsigned SECTION_ID_BITS = mcvr_pkg::SECTION_ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] corner_a_i,
  input  logic [31:0] corner_b_i,
  input  logic [31:0] corner_c_i,
  input  logic [30:0] section_vertex_count_i,
  input  logic [7:0]  section_id_i,
  input  logic        section_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] chunk_number_o,
  output logic [7:0]  chunk_section_o,
  output logic [31:0] source_vertex_o,
  output logic [14:0] local_index_o,
  output logic [14:0] local_a_o,
  output logic [14:0] local_b_o,
  output logic [14:0] local_c_o,
  output logic        last_o
);

  mcvr_pkg::cmd_t    cmd;
  mcvr_pkg::status_t st;

  mcvr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mcvr_dp #(
    .MAX_TRIANGLES   (MAX_TRIANGLES),
    .REMAP_ENTRIES   (REMAP_ENTRIES),
    .SECTION_ID_BITS (SECTION_ID_BITS)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .st_o                   (st),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .corner_a_i             (corner_a_i),
    .corner_b_i             (corner_b_i),
    .corner_c_i             (corner_c_i),
    .section_vertex_count_i (section_vertex_count_i),
    .section_id_i           (section_id_i),
    .section_start_i        (section_start_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .kind_o                 (kind_o),
    .chunk_number_o         (chunk_number_o),
    .chunk_section_o        (chunk_section_o),
    .source_vertex_o        (source_vertex_o),
    .local_index_o          (local_index_o),
    .local_a_o              (local_a_o),
    .local_b_o              (local_b_o),
    .local_c_o              (local_c_o),
    .last_o                 (last_o)
  );

endmodule
